[sv/cbavg_pkg.sv]
package cbavg_pkg;

   localparam int PIX_W      = 16;
   localparam int BIN_W      = 16;
   localparam int ROW_W      = 10;
   localparam int AVG_W      = 16;
   localparam int CIB_W      = 16;
   localparam int CNT_W      = CIB_W + 1;
   localparam int REM_W      = CNT_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CIB_W-1:0] CIB_MAX  = {CIB_W{1'b1}};
   localparam logic [AVG_W-1:0] AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
   localparam logic [AVG_W-1:0] AVG_NEG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

[sv/cbavg_fifo.sv]
module cbavg_fifo
   import cbavg_pkg::*;
#(
   parameter int DATA_W = 75
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output fifo_stat_type     stat
);

   logic [DATA_W-1:0]     entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

[sv/cbavg_front.sv]
module cbavg_front
   import cbavg_pkg::*;
#(
   parameter int MAX_ROWS  = 1024,
   parameter int SUM_WIDTH = 32,
   parameter int JOB_W     = SUM_WIDTH + CNT_W + BIN_W + ROW_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [PIX_W-1:0] req_pixel,
   input  logic [BIN_W-1:0]        req_bin_index,
   input  logic                    req_column_end,
   input  logic                    req_bin_end,
   input  fifo_stat_type           fifo_stat,
   output logic                    push,
   output logic [JOB_W-1:0]        push_data
);

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int FW = $clog2(MAX_ROWS + 1);
   localparam int SW = SUM_WIDTH;

   // Row accumulators. Entries at or above the fill count were never written
   // since reset and read as zero; rows are always visited upward from zero.
   logic [SW-1:0]    row_sum_ff [MAX_ROWS];
   logic [SW-1:0]    mem_q_ff;

   logic [RW-1:0]    row_ff, row_in;
   logic [CIB_W-1:0] cib_ff, cib_in;
   logic [FW-1:0]    fill_ff, fill_in;

   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [BIN_W-1:0] s1_bin_ff;
   logic [RW-1:0]    s1_row_ff;
   logic             s1_bin_end_ff;
   logic [CNT_W-1:0] s1_cnt_ff;
   logic             s1_rd_ok_ff;
   logic             fwd_ff;
   logic [SW-1:0]    fwd_data_ff;

   logic             accept;
   logic             s1_go;
   logic [SW-1:0]    old_sum;
   logic [SW:0]      sum_ext;
   logic [SW-1:0]    sum_sat;
   logic [SW-1:0]    wr_data;
   logic [RW+ROW_W-1:0] row_ext;

   assign s1_go     = s1_valid_ff && (!s1_bin_end_ff || !fifo_stat.full);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (req_column_end || row_ff == RW'(MAX_ROWS - 1)) begin
         row_in = '0;
      end else begin
         row_in = row_ff + 1'b1;
      end

      cib_in = cib_ff;
      if (req_column_end) begin
         if (req_bin_end) begin
            cib_in = '0;
         end else if (cib_ff != CIB_MAX) begin
            cib_in = cib_ff + 1'b1;
         end
      end

      fill_in = fill_ff;
      if (s1_go && FW'(s1_row_ff) == fill_ff) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // Saturating accumulate of the stage-one pixel onto the stored row sum.
   always_comb begin
      if (fwd_ff) begin
         old_sum = fwd_data_ff;
      end else if (s1_rd_ok_ff) begin
         old_sum = mem_q_ff;
      end else begin
         old_sum = '0;
      end
      sum_ext = {old_sum[SW-1], old_sum} + {{(SW+1-PIX_W){s1_pix_ff[PIX_W-1]}}, s1_pix_ff};
      if (sum_ext[SW] != sum_ext[SW-1]) begin
         sum_sat = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sum_sat = sum_ext[SW-1:0];
      end
      wr_data = s1_bin_end_ff ? '0 : sum_sat;
      row_ext = {{ROW_W{1'b0}}, s1_row_ff};
   end

   assign push      = s1_valid_ff && s1_bin_end_ff && !fifo_stat.full;
   assign push_data = {sum_sat, s1_cnt_ff, s1_bin_ff, row_ext[ROW_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         cib_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (accept) begin
            row_ff      <= row_in;
            cib_ff      <= cib_in;
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Stage-one payload; a write to the row being read is forwarded because
   // the memory returns the value from before the write.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= req_pixel;
         s1_bin_ff     <= req_bin_index;
         s1_row_ff     <= row_ff;
         s1_bin_end_ff <= req_bin_end;
         s1_cnt_ff     <= {1'b0, cib_ff} + 1'b1;
         s1_rd_ok_ff   <= (FW'(row_ff) < fill_ff);
         fwd_ff        <= s1_go && (s1_row_ff == row_ff);
         fwd_data_ff   <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         row_sum_ff[s1_row_ff] <= wr_data;
      end
      if (accept) begin
         mem_q_ff <= row_sum_ff[row_ff];
      end
   end

endmodule

[sv/cbavg_div.sv]
module cbavg_div
   import cbavg_pkg::*;
#(
   parameter int SUM_WIDTH = 32,
   parameter int JOB_W     = SUM_WIDTH + CNT_W + BIN_W + ROW_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fifo_stat_type           fifo_stat,
   input  logic [JOB_W-1:0]        pop_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BIN_W-1:0]        rsp_out_bin,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic signed [AVG_W-1:0] rsp_average
);

   localparam int SW   = SUM_WIDTH;
   localparam int IT_W = $clog2(SW);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIX
   } state_type;

   state_type        state_ff;
   logic [SW-1:0]    dq_ff;
   logic [REM_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [IT_W-1:0]  iter_ff;
   logic             neg_ff;
   logic [BIN_W-1:0] bin_ff;
   logic [ROW_W-1:0] row_ff;

   logic             rsp_valid_ff;
   logic [BIN_W-1:0] rsp_bin_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [AVG_W-1:0] rsp_avg_ff;

   logic [SW-1:0]    job_sum;
   logic [CNT_W-1:0] job_cnt;
   logic [BIN_W-1:0] job_bin;
   logic [ROW_W-1:0] job_row;
   logic [SW-1:0]    job_mag;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             q_bit;
   logic [REM_W-1:0] rem_in;
   logic [AVG_W-1:0] avg_in;

   assign {job_sum, job_cnt, job_bin, job_row} = pop_data;
   assign pop = (state_ff == S_IDLE) && !fifo_stat.empty;

   always_comb begin
      job_mag = job_sum[SW-1] ? (~job_sum) + {{(SW-1){1'b0}}, 1'b1} : job_sum;

      // One restoring step: shift in the next dividend bit, subtract if it fits.
      trial  = {rem_ff, dq_ff[SW-1]};
      diff   = trial - {1'b0, cnt_ff};
      q_bit  = (trial >= {1'b0, cnt_ff});
      rem_in = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];

      if (neg_ff) begin
         if (dq_ff > SW'(32768)) begin
            avg_in = AVG_NEG_MIN;
         end else begin
            avg_in = (~dq_ff[AVG_W-1:0]) + {{(AVG_W-1){1'b0}}, 1'b1};
         end
      end else begin
         if (dq_ff > SW'(32767)) begin
            avg_in = AVG_POS_MAX;
         end else begin
            avg_in = dq_ff[AVG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_FIX && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!fifo_stat.empty) begin
                  dq_ff    <= job_mag;
                  rem_ff   <= '0;
                  cnt_ff   <= job_cnt;
                  neg_ff   <= job_sum[SW-1];
                  bin_ff   <= job_bin;
                  row_ff   <= job_row;
                  iter_ff  <= IT_W'(SW - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               dq_ff   <= {dq_ff[SW-2:0], q_bit};
               rem_ff  <= rem_in;
               iter_ff <= iter_ff - 1'b1;
               if (iter_ff == '0) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_bin_ff   <= bin_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_avg_ff   <= avg_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_bin = rsp_bin_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_average = rsp_avg_ff;

endmodule

[sv/column_bin_averager_top.sv]
// Column binning averager.
// The req channel takes one pixel per transaction in column-major order, row
// zero first, with the bin index and the column-end and bin-end flags. Each
// row keeps a saturating running sum over the columns of the open bin. A pixel
// with bin_end set closes its row's sum and yields one rsp transaction carrying
// the bin, the row and the sum divided by the column count, truncated toward
// zero and saturated to 16 bits; other pixels yield nothing.
// Pixels that do not close a bin are taken one per cycle unless a closing
// pixel is stalled in the front. A closing pixel is placed in a four-entry
// queue and served by a restoring divider that takes one job at a time, in
// idle, divide and fix states; the queue absorbs short bursts. With an empty
// queue, a result passes through those states into the register of rsp_valid.
// A stalled receiver holds the result in the output register while the divider
// finishes the next one and waits; once the queue is full, the next closing
// pixel stalls in the front and req_ready drops. Reset clears the row and
// column counters and marks every row sum as zero at once; no clearing pass is
// needed.
module column_bin_averager_top
   import cbavg_pkg::*;
#(
   parameter int MAX_ROWS  = 1024,
   parameter int SUM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [PIX_W-1:0] req_pixel,
   input  logic [BIN_W-1:0]        req_bin_index,
   input  logic                    req_column_end,
   input  logic                    req_bin_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [BIN_W-1:0]        rsp_out_bin,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic signed [AVG_W-1:0] rsp_average
);

   localparam int JOB_W = SUM_WIDTH + CNT_W + BIN_W + ROW_W;

   fifo_stat_type    fifo_stat;
   logic             fifo_push;
   logic             fifo_pop;
   logic [JOB_W-1:0] push_data;
   logic [JOB_W-1:0] pop_data;

   cbavg_front #(
      .MAX_ROWS  (MAX_ROWS),
      .SUM_WIDTH (SUM_WIDTH),
      .JOB_W     (JOB_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .req_bin_index  (req_bin_index),
      .req_column_end (req_column_end),
      .req_bin_end    (req_bin_end),
      .fifo_stat      (fifo_stat),
      .push           (fifo_push),
      .push_data      (push_data)
   );

   cbavg_fifo #(
      .DATA_W (JOB_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   cbavg_div #(
      .SUM_WIDTH (SUM_WIDTH),
      .JOB_W     (JOB_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .fifo_stat   (fifo_stat),
      .pop_data    (pop_data),
      .pop         (fifo_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_bin (rsp_out_bin),
      .rsp_out_row (rsp_out_row),
      .rsp_average (rsp_average)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_stat.full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_stat.empty)
      else $error("queue read while empty");

   a_empty_stays: assert property (@(posedge clock) disable iff (reset)
      (fifo_stat.empty && !fifo_push) |=> fifo_stat.empty)
      else $error("queue left empty state without a write");

endmodule
